// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files of the intra 4x4 luma predictor.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle property failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle property failed");

`endif

// ===== src/i4p_pkg.sv =====
// Types, codes and filter functions of the intra 4x4 luma predictor.
// No dependencies; used by every module of the block.
package i4p_pkg;

	localparam int SLOT_COUNT = 13;
	localparam int IDX_W      = 4;
	localparam int PIX_W      = 8;

	localparam logic [PIX_W-1:0] DC_DEFAULT = 8'd128;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_PRED = 1'b1
	} req_t;

	typedef enum logic [3:0] {
		MODE_V   = 4'd0,
		MODE_H   = 4'd1,
		MODE_DC  = 4'd2,
		MODE_DDL = 4'd3,
		MODE_DDR = 4'd4,
		MODE_VR  = 4'd5,
		MODE_HD  = 4'd6,
		MODE_VL  = 4'd7,
		MODE_HU  = 4'd8
	} mode_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [SLOT_COUNT-1:0] store_t;
	typedef pix_t [3:0] row_t;
	typedef row_t [3:0] block_t;

	typedef struct packed {
		mode_t mode;
		logic  top_ok;
		logic  left_ok;
	} pred_req_t;

	function automatic pix_t avg2(input pix_t a, input pix_t b);
		logic [PIX_W:0] s;
		s = {1'b0, a} + {1'b0, b} + (PIX_W+1)'(1);
		return s[PIX_W:1];
	endfunction

	function automatic pix_t avg3(input pix_t a, input pix_t b, input pix_t c);
		logic [PIX_W+1:0] s;
		s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c} + (PIX_W+2)'(2);
		return s[PIX_W+1:2];
	endfunction

	// (a + 3*b + 2) >> 2, the corner filter at the end of a neighbor line
	function automatic pix_t avg13(input pix_t a, input pix_t b);
		logic [PIX_W+1:0] s;
		s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, b} + (PIX_W+2)'(2);
		return s[PIX_W+1:2];
	endfunction

endpackage

// ===== src/i4p_neighbor_store.sv =====
// Register file of the 13 neighbor pixels (above, above-right, left, corner).
// Depends on i4p_pkg.
module i4p_neighbor_store (
	input  logic                      clk,
	input  logic                      we,
	input  logic [i4p_pkg::IDX_W-1:0] idx,
	input  i4p_pkg::pix_t             din,
	output i4p_pkg::store_t           nb
);

	i4p_pkg::store_t nb_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < i4p_pkg::SLOT_COUNT; i++) begin
			if (we && idx == i4p_pkg::IDX_W'(i)) begin
				nb_q[i] <= din;
			end
		end
	end

	assign nb = nb_q;

endmodule

// ===== src/i4p_pixel_calc.sv =====
// Combinational prediction of all 16 pixels of a 4x4 block from the neighbors.
// Depends on i4p_pkg.
module i4p_pixel_calc (
	input  i4p_pkg::store_t   nb,
	input  i4p_pkg::pred_req_t req,
	output i4p_pkg::block_t   blk
);

	// neighbor line: L3 L2 L1 L0 Q A0 .. A7
	i4p_pkg::pix_t e  [13];
	i4p_pkg::pix_t f2 [12];
	i4p_pkg::pix_t f3 [13];
	i4p_pkg::pix_t px_a [4][4];
	i4p_pkg::pix_t dc;
	i4p_pkg::pix_t sp_a;
	i4p_pkg::pix_t sp_l;
	logic [i4p_pkg::PIX_W+1:0] st;
	logic [i4p_pkg::PIX_W+1:0] sl;
	logic [i4p_pkg::PIX_W+2:0] sa;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			e[5+i] = nb[i];
		end
		for (int i = 0; i < 4; i++) begin
			e[3-i] = nb[8+i];
		end
		e[4] = nb[12];
	end

	always_comb begin
		for (int i = 0; i < 12; i++) begin
			f2[i] = i4p_pkg::avg2(e[i], e[i+1]);
		end
		for (int i = 1; i < 12; i++) begin
			f3[i] = i4p_pkg::avg3(e[i-1], e[i], e[i+1]);
		end
		f3[0]  = e[0];
		f3[12] = e[12];
		sp_a   = i4p_pkg::avg13(e[11], e[12]);
		sp_l   = i4p_pkg::avg13(e[1], e[0]);
	end

	always_comb begin
		st = {2'b00, e[5]} + {2'b00, e[6]} + {2'b00, e[7]} + {2'b00, e[8]}
			+ (i4p_pkg::PIX_W+2)'(2);
		sl = {2'b00, e[0]} + {2'b00, e[1]} + {2'b00, e[2]} + {2'b00, e[3]}
			+ (i4p_pkg::PIX_W+2)'(2);
		sa = {1'b0, st} + {1'b0, sl};
		unique case ({req.top_ok, req.left_ok})
			2'b11: dc = sa[i4p_pkg::PIX_W+2:3];
			2'b01: dc = sl[i4p_pkg::PIX_W+1:2];
			2'b10: dc = st[i4p_pkg::PIX_W+1:2];
			2'b00: dc = i4p_pkg::DC_DEFAULT;
		endcase
	end

	for (genvar Y = 0; Y < 4; Y++) begin : g_row
		for (genvar X = 0; X < 4; X++) begin : g_col
			localparam int DDL_I = (X + Y < 6) ? 6 + X + Y : 6;
			localparam int VR_Z  = 2 * X - Y;
			localparam int VR_K  = X - (Y / 2);
			localparam bit VR_F2 = (VR_Z >= 0) && (VR_Z % 2 == 0);
			localparam int VR_I  = (VR_Z >= 0) ? 4 + VR_K : ((VR_Z == -1) ? 4 : 5 - Y);
			localparam int HD_Z  = 2 * Y - X;
			localparam int HD_K  = Y - (X / 2);
			localparam bit HD_F2 = (HD_Z >= 0) && (HD_Z % 2 == 0);
			localparam int HD_I  = HD_F2 ? 3 - HD_K :
				((HD_Z > 0) ? 4 - HD_K : ((HD_Z == -1) ? 4 : 3 + X));
			localparam int VL_K  = X + (Y / 2);
			localparam bit VL_F2 = (Y % 2 == 0);
			localparam int VL_I  = VL_F2 ? 5 + VL_K : 6 + VL_K;
			localparam int HU_Z  = X + 2 * Y;
			localparam int HU_K  = Y + (X / 2);
			localparam bit HU_L3 = (HU_Z > 5);
			localparam bit HU_SP = (HU_Z == 5);
			localparam bit HU_F2 = (HU_Z % 2 == 0);
			localparam int HU_I  = (HU_Z < 5) ? 2 - HU_K : 1;

			always_comb begin
				unique case (req.mode)
					i4p_pkg::MODE_V:   px_a[Y][X] = e[5+X];
					i4p_pkg::MODE_H:   px_a[Y][X] = e[3-Y];
					i4p_pkg::MODE_DC:  px_a[Y][X] = dc;
					i4p_pkg::MODE_DDL: px_a[Y][X] = (X == 3 && Y == 3) ? sp_a : f3[DDL_I];
					i4p_pkg::MODE_DDR: px_a[Y][X] = f3[4+X-Y];
					i4p_pkg::MODE_VR:  px_a[Y][X] = VR_F2 ? f2[VR_I] : f3[VR_I];
					i4p_pkg::MODE_HD:  px_a[Y][X] = HD_F2 ? f2[HD_I] : f3[HD_I];
					i4p_pkg::MODE_VL:  px_a[Y][X] = VL_F2 ? f2[VL_I] : f3[VL_I];
					i4p_pkg::MODE_HU:  px_a[Y][X] = HU_L3 ? e[0] :
						(HU_SP ? sp_l : (HU_F2 ? f2[HU_I] : f3[HU_I]));
					default:           px_a[Y][X] = '0;
				endcase
			end
		end
	end

	always_comb begin
		for (int y = 0; y < 4; y++) begin
			for (int x = 0; x < 4; x++) begin
				blk[y][x] = px_a[y][x];
			end
		end
	end

endmodule

// ===== src/i4p_row_out.sv =====
// Result register of the predictor: holds one predicted block and sends it
// out one row per handshake. Depends on i4p_pkg.
module i4p_row_out (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  i4p_pkg::block_t blk_in,
	output logic            free,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      row_number,
	output i4p_pkg::pix_t   pixel_col0,
	output i4p_pkg::pix_t   pixel_col1,
	output i4p_pkg::pix_t   pixel_col2,
	output i4p_pkg::pix_t   pixel_col3,
	output logic            last_row
);

	localparam logic [1:0] ROW_LAST = 2'd3;

	logic            vld_s2;
	logic [1:0]      row_s2;
	i4p_pkg::block_t blk_s2;
	logic            pop;

	assign pop  = vld_s2 && !out_stall;
	assign free = !vld_s2 || (pop && row_s2 == ROW_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			row_s2 <= '0;
		end else if (load) begin
			vld_s2 <= 1'b1;
			row_s2 <= '0;
		end else if (pop && row_s2 == ROW_LAST) begin
			vld_s2 <= 1'b0;
		end else if (pop) begin
			row_s2 <= row_s2 + 2'd1;
		end
	end

	// shift the next row into the output slot
	always_ff @(posedge clk) begin
		if (load) begin
			blk_s2 <= blk_in;
		end else if (pop) begin
			for (int r = 0; r < 3; r++) begin
				blk_s2[r] <= blk_s2[r+1];
			end
			blk_s2[3] <= '0;
		end
	end

	assign out_valid  = vld_s2;
	assign row_number = row_s2;
	assign pixel_col0 = blk_s2[0][0];
	assign pixel_col1 = blk_s2[0][1];
	assign pixel_col2 = blk_s2[0][2];
	assign pixel_col3 = blk_s2[0][3];
	assign last_row   = (row_s2 == ROW_LAST);

endmodule

// ===== src/intra4x4_luma_predictor.sv =====
// Intra 4x4 luma predictor, top level.
// Depends on i4p_pkg, i4p_neighbor_store, i4p_pixel_calc and i4p_row_out.
//
// Input channel (in_valid / in_stall): a load request (req_type 0) writes
// neighbor_value into neighbor slot neighbor_index (0..7 above, 8..11 left,
// 12 corner; 13..15 write nothing) and produces no result. A predict request
// (req_type 1) with pred_mode 0..8 produces four row results; modes 9..15
// are dropped. Loads are taken one per cycle while in_stall is low.
// Output channel (out_valid / out_stall): rows 0..3 of the block, top first,
// last_row set on row 3. The first row is valid once the request register
// has passed the predict to the row register, then one row per cycle while
// out_stall is low. A predict holds the row register for its four rows; one
// further predict waits in the request register, so back-to-back predicts
// keep the output busy every cycle and in_stall rises while both are full.
// When the receiver stalls, the current row holds and, once the request
// register is full, in_stall stays high. Reset clears all valid state; the
// neighbor slots read as undefined until they are loaded.
module intra4x4_luma_predictor (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      req_type,
	input  logic [i4p_pkg::IDX_W-1:0] neighbor_index,
	input  i4p_pkg::pix_t             neighbor_value,
	input  logic [3:0]                pred_mode,
	input  logic                      top_ok,
	input  logic                      left_ok,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                row_number,
	output i4p_pkg::pix_t             pixel_col0,
	output i4p_pkg::pix_t             pixel_col1,
	output i4p_pkg::pix_t             pixel_col2,
	output i4p_pkg::pix_t             pixel_col3,
	output logic                      last_row
);

	logic               in_accept;
	logic               load_we;
	logic               pred_take;
	logic               blk_free;
	logic               blk_load;
	logic               req_vld_s1;
	i4p_pkg::pred_req_t req_s1;
	i4p_pkg::store_t    nb;
	i4p_pkg::block_t    blk;

	assign blk_load  = req_vld_s1 && blk_free;
	assign in_stall  = req_vld_s1 && !blk_free;
	assign in_accept = in_valid && !in_stall;
	assign load_we   = in_accept && (req_type == i4p_pkg::REQ_LOAD);
	assign pred_take = in_accept && (req_type == i4p_pkg::REQ_PRED)
		&& (pred_mode <= i4p_pkg::MODE_HU);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1 <= 1'b0;
		end else if (pred_take) begin
			req_vld_s1 <= 1'b1;
		end else if (blk_load) begin
			req_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pred_take) begin
			req_s1 <= i4p_pkg::pred_req_t'{
				mode:    i4p_pkg::mode_t'(pred_mode),
				top_ok:  top_ok,
				left_ok: left_ok
			};
		end
	end

	i4p_neighbor_store u_store (
		.clk (clk),
		.we  (load_we),
		.idx (neighbor_index),
		.din (neighbor_value),
		.nb  (nb)
	);

	i4p_pixel_calc u_calc (
		.nb  (nb),
		.req (req_s1),
		.blk (blk)
	);

	i4p_row_out u_rows (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (blk_load),
		.blk_in     (blk),
		.free       (blk_free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row_number (row_number),
		.pixel_col0 (pixel_col0),
		.pixel_col1 (pixel_col1),
		.pixel_col2 (pixel_col2),
		.pixel_col3 (pixel_col3),
		.last_row   (last_row)
	);

endmodule

// ===== src/i4p_checker.sv =====
// Port-level checks of the intra 4x4 luma predictor, bound to its top level.
// Depends on assert_macros.svh and i4p_pkg.
`include "assert_macros.svh"

module i4p_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input logic [1:0]    row_number,
	input i4p_pkg::pix_t pixel_col0,
	input i4p_pkg::pix_t pixel_col1,
	input i4p_pkg::pix_t pixel_col2,
	input i4p_pkg::pix_t pixel_col3,
	input logic          last_row
);

	logic [33:0] row_bus;

	assign row_bus = {row_number, pixel_col3, pixel_col2, pixel_col1, pixel_col0};

	`ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid)
	`ASSERT_NEXT(a_hold_row, out_valid && out_stall, $stable(row_bus))
	`ASSERT_NEXT(a_row_step, out_valid && !out_stall && !last_row, out_valid && (row_number == $past(row_number) + 2'd1))
	`ASSERT_NOW(a_last_flag, out_valid, last_row == (row_number == 2'd3))
	`ASSERT_NOW(a_no_stall_idle, !out_valid, !in_stall)

endmodule

bind intra4x4_luma_predictor i4p_checker u_i4p_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.row_number (row_number),
	.pixel_col0 (pixel_col0),
	.pixel_col1 (pixel_col1),
	.pixel_col2 (pixel_col2),
	.pixel_col3 (pixel_col3),
	.last_row   (last_row)
);

// ===== tb/i4p_block_checker.sv =====
`timescale 1ns / 1ps
// Checker for the intra 4x4 luma predictor: watches both channels, keeps its own neighbor store,
// predicts the four rows of each block and compares them with the rows that leave the block.
// Depends on i4p_pkg for pixel types and request and mode codes.
module i4p_block_checker
	import i4p_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic             req_type,
	input  logic [IDX_W-1:0] neighbor_index,
	input  pix_t             neighbor_value,
	input  logic [3:0]       pred_mode,
	input  logic             top_ok,
	input  logic             left_ok,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [1:0]       row_number,
	input  pix_t             pixel_col0,
	input  pix_t             pixel_col1,
	input  pix_t             pixel_col2,
	input  pix_t             pixel_col3,
	input  logic             last_row,
	output int               mismatches,
	output int               rows_owed,
	output int               rows_matched
);

	localparam int CORNER_SLOT = SLOT_COUNT - 1;
	localparam int LEFT_BASE   = 8;
	localparam int PIX_MAX     = (1 << PIX_W) - 1;

	typedef struct packed {
		logic [1:0] row;
		row_t       pix;
		logic       last;
	} pred_row_t;

	pix_t      nbr_pix [SLOT_COUNT];
	pred_row_t rows_due [$];

	function automatic int nbr(int x, int y);
		if (x < 0 && y < 0)
			return nbr_pix[CORNER_SLOT];
		if (y < 0)
			return nbr_pix[x & 7];
		return nbr_pix[LEFT_BASE + (y & 3)];
	endfunction

	function automatic int tap2(int a, int b);
		return (a + b + 1) >>> 1;
	endfunction

	function automatic int tap3(int a, int b, int c);
		return (a + 2 * b + c + 2) >>> 2;
	endfunction

	function automatic int pel(logic [3:0] mode, int x, int y, int dc);
		int z;
		int k;
		case (mode)
			MODE_V:  return nbr(x, -1);
			MODE_H:  return nbr(-1, y);
			MODE_DC: return dc;
			MODE_DDL: begin
				if (x == 3 && y == 3)
					return (nbr(6, -1) + 3 * nbr(7, -1) + 2) >>> 2;
				return tap3(nbr(x + y, -1), nbr(x + y + 1, -1), nbr(x + y + 2, -1));
			end
			MODE_DDR: begin
				if (x > y)
					return tap3(nbr(x - y - 2, -1), nbr(x - y - 1, -1), nbr(x - y, -1));
				if (x < y)
					return tap3(nbr(-1, y - x - 2), nbr(-1, y - x - 1), nbr(-1, y - x));
				return tap3(nbr(0, -1), nbr(-1, -1), nbr(-1, 0));
			end
			MODE_VR: begin
				z = 2 * x - y;
				k = x - (y >>> 1);
				if (z >= 0 && z % 2 == 0)
					return tap2(nbr(k - 1, -1), nbr(k, -1));
				if (z > 0)
					return tap3(nbr(k - 2, -1), nbr(k - 1, -1), nbr(k, -1));
				if (z == -1)
					return tap3(nbr(-1, 0), nbr(-1, -1), nbr(0, -1));
				return tap3(nbr(-1, y - 1), nbr(-1, y - 2), nbr(-1, y - 3));
			end
			MODE_HD: begin
				z = 2 * y - x;
				k = y - (x >>> 1);
				if (z >= 0 && z % 2 == 0)
					return tap2(nbr(-1, k - 1), nbr(-1, k));
				if (z > 0)
					return tap3(nbr(-1, k - 2), nbr(-1, k - 1), nbr(-1, k));
				if (z == -1)
					return tap3(nbr(-1, 0), nbr(-1, -1), nbr(0, -1));
				return tap3(nbr(x - 1, -1), nbr(x - 2, -1), nbr(x - 3, -1));
			end
			MODE_VL: begin
				k = x + (y >>> 1);
				if (y % 2 == 0)
					return tap2(nbr(k, -1), nbr(k + 1, -1));
				return tap3(nbr(k, -1), nbr(k + 1, -1), nbr(k + 2, -1));
			end
			default: begin
				z = x + 2 * y;
				k = y + (x >>> 1);
				if (z > 5)
					return nbr(-1, 3);
				if (z == 5)
					return (nbr(-1, 2) + 3 * nbr(-1, 3) + 2) >>> 2;
				if (z % 2 == 0)
					return tap2(nbr(-1, k), nbr(-1, k + 1));
				return tap3(nbr(-1, k), nbr(-1, k + 1), nbr(-1, k + 2));
			end
		endcase
	endfunction

	task automatic predict_block(logic [3:0] mode, logic t_ok, logic l_ok);
		int        sum_top;
		int        sum_left;
		int        dc;
		int        v;
		pred_row_t r;
		sum_top  = 0;
		sum_left = 0;
		dc       = DC_DEFAULT;
		for (int i = 0; i < 4; i++) begin
			sum_top  += nbr(i, -1);
			sum_left += nbr(-1, i);
		end
		if (mode == MODE_DC) begin
			if (t_ok && l_ok)
				dc = (sum_top + sum_left + 4) >>> 3;
			else if (l_ok)
				dc = (sum_left + 2) >>> 2;
			else if (t_ok)
				dc = (sum_top + 2) >>> 2;
		end
		for (int y = 0; y < 4; y++) begin
			r.row  = 2'(y);
			r.last = (y == 3);
			for (int x = 0; x < 4; x++) begin
				v = pel(mode, x, y, dc);
				v = v < 0 ? 0 : (v > PIX_MAX ? PIX_MAX : v);
				r.pix[x] = pix_t'(v);
			end
			rows_due.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pred_row_t want;
		pred_row_t got;
		if (!arst_n) begin
			rows_due.delete();
			foreach (nbr_pix[i])
				nbr_pix[i] = '0;
			mismatches   = 0;
			rows_owed    = 0;
			rows_matched = 0;
		end else begin
			if (in_valid && !in_stall) begin
				if (req_type == REQ_LOAD) begin
					if (neighbor_index < SLOT_COUNT)
						nbr_pix[neighbor_index] = neighbor_value;
				end else if (pred_mode <= MODE_HU) begin
					predict_block(pred_mode, top_ok, left_ok);
				end
			end
			if (out_valid && !out_stall) begin
				got.row = row_number;
				got.pix = {pixel_col3, pixel_col2, pixel_col1, pixel_col0};
				got.last = last_row;
				if (rows_due.size() == 0) begin
					$display("%0t: unexpected row, expected none, got row %0d pixels %h",
						$time, got.row, got.pix);
					mismatches++;
				end else begin
					want = rows_due.pop_front();
					if (got.row !== want.row) begin
						$display("%0t: row_number mismatch, expected %0d, got %0d",
							$time, want.row, got.row);
						mismatches++;
					end
					for (int c = 0; c < 4; c++) begin
						if (got.pix[c] !== want.pix[c]) begin
							$display("%0t: row %0d pixel_col%0d mismatch, expected %0d, got %0d",
								$time, want.row, c, want.pix[c], got.pix[c]);
							mismatches++;
						end
					end
					if (got.last !== want.last) begin
						$display("%0t: row %0d last_row mismatch, expected %0b, got %0b",
							$time, want.row, want.last, got.last);
						mismatches++;
					end
					rows_matched++;
				end
			end
			rows_owed = rows_due.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the intra 4x4 luma predictor testbench: clock, reset, neighbor loads and block
// requests with random idling on both channels, and the verdict. Depends on i4p_pkg, the
// block and i4p_block_checker.
module tb_top;
	import i4p_pkg::*;

	localparam int HALF_PERIOD  = 2;
	localparam int RESET_CYCLES = 7;
	localparam int ITEMS        = 370;
	localparam int TAIL_CYCLES  = 12;
	localparam int LIMIT_NS     = 2_000_000;
	localparam int IDX_MAX      = (1 << IDX_W) - 1;
	localparam int MODE_MAX     = 15;
	localparam int PIX_MAX      = (1 << PIX_W) - 1;

	localparam pix_t SEED_PIX [SLOT_COUNT] = '{
		8'd255, 8'd0, 8'd255, 8'd0, 8'd1, 8'd254, 8'd128, 8'd255,
		8'd0, 8'd255, 8'd3, 8'd254, 8'd255
	};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic             req_type;
	logic [IDX_W-1:0] neighbor_index;
	pix_t             neighbor_value;
	logic [3:0]       pred_mode;
	logic             top_ok;
	logic             left_ok;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [1:0]       row_number;
	pix_t             pixel_col0;
	pix_t             pixel_col1;
	pix_t             pixel_col2;
	pix_t             pixel_col3;
	logic             last_row;

	int mismatches;
	int rows_owed;
	int rows_matched;
	int send_pct = 0;
	int recv_pct = 0;
	int loads_done = 0;
	int blocks_done = 0;
	int ignored_done = 0;

	intra4x4_luma_predictor dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.neighbor_index (neighbor_index),
		.neighbor_value (neighbor_value),
		.pred_mode      (pred_mode),
		.top_ok         (top_ok),
		.left_ok        (left_ok),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.row_number     (row_number),
		.pixel_col0     (pixel_col0),
		.pixel_col1     (pixel_col1),
		.pixel_col2     (pixel_col2),
		.pixel_col3     (pixel_col3),
		.last_row       (last_row)
	);

	i4p_block_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.neighbor_index (neighbor_index),
		.neighbor_value (neighbor_value),
		.pred_mode      (pred_mode),
		.top_ok         (top_ok),
		.left_ok        (left_ok),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.row_number     (row_number),
		.pixel_col0     (pixel_col0),
		.pixel_col1     (pixel_col1),
		.pixel_col2     (pixel_col2),
		.pixel_col3     (pixel_col3),
		.last_row       (last_row),
		.mismatches     (mismatches),
		.rows_owed      (rows_owed),
		.rows_matched   (rows_matched)
	);

	always #(HALF_PERIOD) clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_pct);
	end

	initial begin
		#(LIMIT_NS);
		$display("status: fail");
		$finish;
	end

	function automatic pix_t pick_pix();
		case ($urandom_range(9))
			0:       return '0;
			1:       return pix_t'(PIX_MAX);
			default: return pix_t'($urandom_range(PIX_MAX));
		endcase
	endfunction

	// Call at a falling edge; returns at the falling edge after the request is taken.
	task automatic push_request(req_t rt, logic [IDX_W-1:0] idx, pix_t val,
		logic [3:0] mode, logic t_ok, logic l_ok);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		req_type       <= rt;
		neighbor_index <= idx;
		neighbor_value <= val;
		pred_mode      <= mode;
		top_ok         <= t_ok;
		left_ok        <= l_ok;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		if (rt == REQ_LOAD) begin
			if (idx < SLOT_COUNT)
				loads_done++;
			else
				ignored_done++;
		end else if (mode <= MODE_HU) begin
			blocks_done++;
		end else begin
			ignored_done++;
		end
	endtask

	task automatic load_pixel(int idx, pix_t val);
		push_request(REQ_LOAD, IDX_W'(idx), val, 4'($urandom_range(MODE_MAX)),
			1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	task automatic request_block(int mode, logic t_ok, logic l_ok);
		push_request(REQ_PRED, IDX_W'($urandom_range(IDX_MAX)), pix_t'($urandom), 4'(mode),
			t_ok, l_ok);
	endtask

	task automatic run_directed();
		for (int s = 0; s < SLOT_COUNT; s++)
			load_pixel(s, SEED_PIX[s]);
		for (int m = MODE_V; m <= MODE_HU; m++)
			request_block(m, 1'b1, 1'b1);
		request_block(MODE_DC, 1'b1, 1'b0);
		request_block(MODE_DC, 1'b0, 1'b1);
		request_block(MODE_DC, 1'b0, 1'b0);
		load_pixel(IDX_MAX, '0);
		request_block(MODE_MAX, 1'b1, 1'b1);
		request_block(MODE_HU, 1'b0, 1'b0);
	endtask

	task automatic run_random(int target);
		int   done_cnt;
		int   n;
		pix_t flat;
		done_cnt = 0;
		while (done_cnt < target) begin
			if ($urandom_range(9) == 0) begin
				if ($urandom_range(1))
					load_pixel($urandom_range(IDX_MAX, SLOT_COUNT), pick_pix());
				else
					request_block($urandom_range(MODE_MAX, int'(MODE_HU) + 1),
						1'($urandom_range(1)), 1'($urandom_range(1)));
				done_cnt += 1;
			end else begin
				n = $urandom_range(5);
				if ($urandom_range(15) == 0) begin
					flat = $urandom_range(1) ? pix_t'(PIX_MAX) : pix_t'(0);
					for (int s = 0; s < SLOT_COUNT; s++)
						load_pixel(s, flat);
					done_cnt += SLOT_COUNT;
				end
				repeat (n)
					load_pixel($urandom_range(SLOT_COUNT - 1), pick_pix());
				request_block($urandom_range(MODE_HU), 1'($urandom_range(1)),
					1'($urandom_range(1)));
				done_cnt += n + 1;
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		req_type       = REQ_LOAD;
		neighbor_index = '0;
		neighbor_value = '0;
		pred_mode      = MODE_V;
		top_ok         = 1'b0;
		left_ok        = 1'b0;
		repeat (RESET_CYCLES)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_pct = 14;
		recv_pct = 65;
		run_directed();
		run_random(ITEMS / 3);

		send_pct = 65;
		recv_pct = 14;
		run_random(ITEMS / 3);

		send_pct = 0;
		recv_pct = 0;
		run_random(ITEMS - 2 * (ITEMS / 3));

		in_valid <= 1'b0;
		while (rows_owed != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES)
			@(negedge clk);

		$display("covered %0d neighbor loads, %0d block requests over all nine modes and DC",
			loads_done, blocks_done);
		$display("availability cases, %0d ignored requests, %0d rows compared",
			ignored_done, rows_matched);
		if (mismatches == 0 && rows_owed == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
